[src/timer_slot_pool_macros.svh]
// Assertion macros used by the timer slot pool checker.
`ifndef TIMER_SLOT_POOL_MACROS_SVH
`define TIMER_SLOT_POOL_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define TSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/tsp_pkg.sv]
// Types and constants of the timer slot pool.
`default_nettype none

package tsp_pkg;

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int HANDLE_W = 4;
  localparam int STATUS_W = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_DELETE  = 3'd3,
    OP_RESTART = 3'd4,
    OP_POLL    = 3'd5
  } op_t;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DISABLED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_PER = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD      = 3'd4;

  // Command as it travels down the cell row.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CREATE,
    CMD_ARM,
    CMD_STOP,
    CMD_DELETE,
    CMD_POLL
  } cmd_t;

  typedef struct packed {
    logic                valid;
    cmd_t                cmd;
    logic [HANDLE_W-1:0] handle;
    logic [PERIOD_W-1:0] period;
    logic                reload;
    logic                notify;
    logic [TIME_W-1:0]   now;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
  } tok_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
  } evt_t;

endpackage

`default_nettype wire

[src/timer_slot_pool.sv]
// Timer slot pool top level: command decode, cell row and result register.
//
// Pool of POOL_SIZE timer slots held in a row of cells. Each accepted command
// beat walks the row one cell per cycle while the result side does not stall,
// and the next command is taken once its closing beat is in the output
// register. A poll may add one expiry beat per due slot with notify set, in
// slot order, before its done beat. Any stall on the result side freezes the
// whole row. pool_enable gates create and poll only; write it while the pool
// is idle.
`default_nettype none

module timer_slot_pool #(
  parameter int POOL_SIZE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] slot_handle, [35:4] period, [36] periodic,
  // [37] notify_on_expiry, [85:38] now_ms, [87:86] zero
  input  wire logic [87:0] s_axis_tdata,
  // [2:0] op
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] status, [6:3] handle_out, [7] zero
  output logic [7:0]       m_axis_tdata,
  // [0] kind
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);

  logic                            pool_enable;
  logic                            adv;
  logic                            busy;
  logic                            acc;
  tsp_pkg::tok_t                   chain [POOL_SIZE+1];
  tsp_pkg::tok_t                   in_tok;
  tsp_pkg::evt_t                   evts [POOL_SIZE];
  tsp_pkg::evt_t                   evt_any;
  logic [POOL_SIZE-1:0]            busy_vec;

  logic [tsp_pkg::HANDLE_W-1:0]    in_handle;
  logic [tsp_pkg::PERIOD_W-1:0]    in_period;
  logic                            hok;

  logic                            kind_r;
  logic [tsp_pkg::STATUS_W-1:0]    status_r;
  logic [tsp_pkg::HANDLE_W-1:0]    handle_r;
  logic                            last_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_enable <= 1'b0;
    end else if (cfg_wr_en) begin
      pool_enable <= cfg_wr_data;
    end
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign busy          = |busy_vec;
  assign s_axis_tready = !busy && adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign in_handle = s_axis_tdata[3:0];
  assign in_period = s_axis_tdata[35:4];
  assign hok       = (in_handle != '0) && ({3'b000, in_handle} <= 7'(POOL_SIZE));

  always_comb begin
    in_tok            = '0;
    in_tok.valid      = acc;
    in_tok.handle     = in_handle;
    in_tok.period     = in_period;
    in_tok.reload     = s_axis_tdata[36];
    in_tok.notify     = s_axis_tdata[37];
    in_tok.now        = s_axis_tdata[85:38];
    in_tok.cmd        = tsp_pkg::CMD_NONE;
    in_tok.status     = tsp_pkg::ST_BAD;
    in_tok.handle_out = '0;
    unique case (s_axis_tuser)
      tsp_pkg::OP_CREATE: begin
        if (!pool_enable) begin
          in_tok.status = tsp_pkg::ST_DISABLED;
        end else if (in_period == '0) begin
          in_tok.status = tsp_pkg::ST_ZERO_PER;
        end else begin
          in_tok.cmd    = tsp_pkg::CMD_CREATE;
          in_tok.status = tsp_pkg::ST_FULL;
        end
      end
      tsp_pkg::OP_START, tsp_pkg::OP_RESTART: begin
        if (hok) in_tok.cmd = tsp_pkg::CMD_ARM;
      end
      tsp_pkg::OP_STOP: begin
        if (hok) begin
          in_tok.cmd    = tsp_pkg::CMD_STOP;
          in_tok.status = tsp_pkg::ST_OK;
        end
      end
      tsp_pkg::OP_DELETE: begin
        if (hok) begin
          in_tok.cmd    = tsp_pkg::CMD_DELETE;
          in_tok.status = tsp_pkg::ST_OK;
        end
      end
      tsp_pkg::OP_POLL: begin
        if (!pool_enable) begin
          in_tok.status = tsp_pkg::ST_DISABLED;
        end else begin
          in_tok.cmd    = tsp_pkg::CMD_POLL;
          in_tok.status = tsp_pkg::ST_OK;
        end
      end
      default: begin
      end
    endcase
  end

  assign chain[0] = in_tok;

  for (genvar k = 0; k < POOL_SIZE; k++) begin : g_cell
    tsp_cell #(
      .IDX(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1]),
      .evt     (evts[k])
    );
    assign busy_vec[k] = chain[k+1].valid;
  end

  // At most one cell holds the token, so at most one event is valid and the merge is exact.
  always_comb begin
    evt_any = '0;
    for (int k = 0; k < POOL_SIZE; k++) begin
      if (evts[k].valid) evt_any = evts[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      if (evt_any.valid) begin
        m_axis_tvalid <= 1'b1;
        kind_r        <= 1'b1;
        status_r      <= tsp_pkg::ST_OK;
        handle_r      <= evt_any.handle;
        last_r        <= 1'b0;
      end else if (chain[POOL_SIZE].valid) begin
        m_axis_tvalid <= 1'b1;
        kind_r        <= 1'b0;
        status_r      <= chain[POOL_SIZE].status;
        handle_r      <= chain[POOL_SIZE].handle_out;
        last_r        <= 1'b1;
      end else begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {1'b0, handle_r, status_r};
  assign m_axis_tuser = kind_r;
  assign m_axis_tlast = last_r;

endmodule

`default_nettype wire

[src/tsp_cell.sv]
// One timer slot: holds its state and passes the command token on.
`default_nettype none

module tsp_cell #(
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire tsp_pkg::tok_t tok_in,
  output tsp_pkg::tok_t      tok_out,
  output tsp_pkg::evt_t      evt
);

  localparam logic [6:0] SLOT_NUM = 7'(IDX + 1);

  logic                          active, active_next;
  logic                          reload, reload_next;
  logic                          notify, notify_next;
  logic [tsp_pkg::PERIOD_W-1:0]  period, period_next;
  logic [tsp_pkg::TIME_W-1:0]    deadline, deadline_next;
  tsp_pkg::tok_t                 tok, tok_next;

  logic                          proc;
  logic                          match;
  logic                          due;
  logic [tsp_pkg::TIME_W:0]      sum;
  logic [tsp_pkg::TIME_W-1:0]    sat;

  assign proc  = adv && tok_in.valid;
  assign match = ({3'b000, tok_in.handle} == SLOT_NUM);
  assign sum   = {1'b0, tok_in.now} + {{(tsp_pkg::TIME_W + 1 - tsp_pkg::PERIOD_W){1'b0}}, period};
  assign sat   = sum[tsp_pkg::TIME_W] ? tsp_pkg::TIME_MAX : sum[tsp_pkg::TIME_W-1:0];
  assign due   = active && (deadline != '0) && (tok_in.now >= deadline);

  always_comb begin
    active_next   = active;
    reload_next   = reload;
    notify_next   = notify;
    period_next   = period;
    deadline_next = deadline;
    tok_next      = tok_in;
    evt.valid     = 1'b0;
    evt.handle    = tsp_pkg::HANDLE_W'(IDX + 1);
    if (proc) begin
      unique case (tok_in.cmd)
        tsp_pkg::CMD_CREATE: begin
          if (!active && tok_in.status == tsp_pkg::ST_FULL) begin
            active_next         = 1'b1;
            reload_next         = tok_in.reload;
            notify_next         = tok_in.notify;
            period_next         = tok_in.period;
            deadline_next       = '0;
            tok_next.status     = tsp_pkg::ST_OK;
            tok_next.handle_out = tsp_pkg::HANDLE_W'(IDX + 1);
          end
        end
        tsp_pkg::CMD_ARM: begin
          if (match && active) begin
            deadline_next   = sat;
            tok_next.status = tsp_pkg::ST_OK;
          end
        end
        tsp_pkg::CMD_STOP: begin
          if (match) deadline_next = '0;
        end
        tsp_pkg::CMD_DELETE: begin
          if (match) begin
            active_next   = 1'b0;
            reload_next   = 1'b0;
            notify_next   = 1'b0;
            period_next   = '0;
            deadline_next = '0;
          end
        end
        tsp_pkg::CMD_POLL: begin
          if (due) begin
            deadline_next = reload ? sat : '0;
            evt.valid     = notify;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      reload    <= 1'b0;
      notify    <= 1'b0;
      period    <= '0;
      deadline  <= '0;
      tok.valid <= 1'b0;
    end else begin
      active   <= active_next;
      reload   <= reload_next;
      notify   <= notify_next;
      period   <= period_next;
      deadline <= deadline_next;
      if (adv) tok <= tok_next;
    end
  end

  assign tok_out = tok;

endmodule

`default_nettype wire

[src/tsp_checker.sv]
// Port-level checks of the timer slot pool, bound to the top level.
`default_nettype none
`include "timer_slot_pool_macros.svh"

module tsp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);

  `TSP_ASSERT_NXT(a_one_cmd, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "command taken while busy")

  `TSP_ASSERT_IMP(a_exp_not_last, clk, rst, m_axis_tvalid && m_axis_tuser, !m_axis_tlast, "expiry beat closes run")

  `TSP_ASSERT_IMP(a_exp_ok, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata[2:0] == 3'd0, "expiry beat has status")

  `TSP_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result beat changed")

endmodule

bind timer_slot_pool tsp_checker u_tsp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[tb/timer_slot_pool_test.sv]
// Testbench for timer_slot_pool: directed and random commands checked against a slot-pool model.
`timescale 1ns / 1ps

module timer_slot_pool_test;

  localparam int SLOTS      = 8;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [2:0]                   op;
    logic [tsp_pkg::HANDLE_W-1:0] handle;
    logic [tsp_pkg::PERIOD_W-1:0] period;
    logic                         reload;
    logic                         notify;
    logic [tsp_pkg::TIME_W-1:0]   now;
  } pool_cmd_t;

  typedef struct packed {
    logic                         kind;
    logic [tsp_pkg::STATUS_W-1:0] status;
    logic [tsp_pkg::HANDLE_W-1:0] handle;
    logic                         last;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_tvalid    = 1'b0;
  logic [87:0] s_tdata     = '0;
  logic [2:0]  s_tuser     = '0;
  logic        m_ready     = 1'b0;

  wire       s_axis_tready;
  wire       m_axis_tvalid;
  wire [7:0] m_axis_tdata;
  wire       m_axis_tuser;
  wire       m_axis_tlast;

  timer_slot_pool #(.POOL_SIZE(SLOTS)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Slot pool model
  bit                           pool_on;
  bit                           slot_on  [SLOTS];
  bit                           slot_rel [SLOTS];
  bit                           slot_ntf [SLOTS];
  logic [tsp_pkg::PERIOD_W-1:0] slot_per [SLOTS];
  logic [tsp_pkg::TIME_W-1:0]   slot_due [SLOTS];

  pool_cmd_t    pending_cmds[$];
  result_beat_t expected_beats[$];
  pool_cmd_t    cur_cmd;

  int unsigned mismatches = 0;
  int unsigned gap_cnt    = 0;
  int unsigned stall_cnt  = 0;
  int unsigned idle_cnt   = 0;
  bit          no_idle    = 1'b0;
  logic [tsp_pkg::TIME_W-1:0] sim_ms = '0;

  function automatic logic [tsp_pkg::TIME_W-1:0] due_at(
      logic [tsp_pkg::TIME_W-1:0] t, logic [tsp_pkg::PERIOD_W-1:0] p);
    logic [tsp_pkg::TIME_W:0] s;
    s = {1'b0, t} + {{(tsp_pkg::TIME_W-tsp_pkg::PERIOD_W+1){1'b0}}, p};
    return (s > {1'b0, tsp_pkg::TIME_MAX}) ? tsp_pkg::TIME_MAX
                                           : s[tsp_pkg::TIME_W-1:0];
  endfunction

  function automatic void add_beat(logic kind, logic [tsp_pkg::STATUS_W-1:0] st,
                                   logic [tsp_pkg::HANDLE_W-1:0] h, logic last);
    result_beat_t b;
    b.kind   = kind;
    b.status = st;
    b.handle = h;
    b.last   = last;
    expected_beats.push_back(b);
  endfunction

  task automatic apply_command(input pool_cmd_t c);
    bit hok;
    bit placed;
    int idx;
    hok    = (c.handle >= 1) && (c.handle <= SLOTS);
    idx    = hok ? int'(c.handle) - 1 : 0;
    placed = 1'b0;
    case (c.op)
      tsp_pkg::OP_CREATE: begin
        if (!pool_on) begin
          add_beat(1'b0, tsp_pkg::ST_DISABLED, '0, 1'b1);
        end else if (c.period == '0) begin
          add_beat(1'b0, tsp_pkg::ST_ZERO_PER, '0, 1'b1);
        end else begin
          for (int k = 0; k < SLOTS; k++) begin
            if (!placed && !slot_on[k]) begin
              slot_on[k]  = 1'b1;
              slot_rel[k] = c.reload;
              slot_ntf[k] = c.notify;
              slot_per[k] = c.period;
              slot_due[k] = '0;
              add_beat(1'b0, tsp_pkg::ST_OK, tsp_pkg::HANDLE_W'(k + 1), 1'b1);
              placed = 1'b1;
            end
          end
          if (!placed) add_beat(1'b0, tsp_pkg::ST_FULL, '0, 1'b1);
        end
      end
      tsp_pkg::OP_START, tsp_pkg::OP_RESTART: begin
        if (!hok || !slot_on[idx]) begin
          add_beat(1'b0, tsp_pkg::ST_BAD, '0, 1'b1);
        end else begin
          slot_due[idx] = due_at(c.now, slot_per[idx]);
          add_beat(1'b0, tsp_pkg::ST_OK, '0, 1'b1);
        end
      end
      tsp_pkg::OP_STOP: begin
        if (!hok) begin
          add_beat(1'b0, tsp_pkg::ST_BAD, '0, 1'b1);
        end else begin
          slot_due[idx] = '0;
          add_beat(1'b0, tsp_pkg::ST_OK, '0, 1'b1);
        end
      end
      tsp_pkg::OP_DELETE: begin
        if (!hok) begin
          add_beat(1'b0, tsp_pkg::ST_BAD, '0, 1'b1);
        end else begin
          slot_on[idx]  = 1'b0;
          slot_rel[idx] = 1'b0;
          slot_ntf[idx] = 1'b0;
          slot_per[idx] = '0;
          slot_due[idx] = '0;
          add_beat(1'b0, tsp_pkg::ST_OK, '0, 1'b1);
        end
      end
      tsp_pkg::OP_POLL: begin
        if (!pool_on) begin
          add_beat(1'b0, tsp_pkg::ST_DISABLED, '0, 1'b1);
        end else begin
          for (int k = 0; k < SLOTS; k++) begin
            if (slot_on[k] && slot_due[k] != '0 && c.now >= slot_due[k]) begin
              slot_due[k] = slot_rel[k] ? due_at(c.now, slot_per[k]) : '0;
              if (slot_ntf[k])
                add_beat(1'b1, tsp_pkg::ST_OK, tsp_pkg::HANDLE_W'(k + 1), 1'b0);
            end
          end
          add_beat(1'b0, tsp_pkg::ST_OK, '0, 1'b1);
        end
      end
      default: add_beat(1'b0, tsp_pkg::ST_BAD, '0, 1'b1);
    endcase
  endtask

  function int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_cnt = 0;
    end else begin
      if (s_tvalid && s_axis_tready) apply_command(cur_cmd);
      if (!s_tvalid || s_axis_tready) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_tdata <= {2'b00, cur_cmd.now, cur_cmd.notify, cur_cmd.reload,
                      cur_cmd.period, cur_cmd.handle};
          s_tuser <= cur_cmd.op;
          s_tvalid <= 1'b1;
          if (!no_idle && $urandom_range(0, 2) == 0) gap_cnt = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    result_beat_t got;
    result_beat_t want;
    if (rst) begin
      m_ready <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        got.kind   = m_axis_tuser;
        got.status = m_axis_tdata[2:0];
        got.handle = m_axis_tdata[6:3];
        got.last   = m_axis_tlast;
        if (expected_beats.size() == 0) begin
          if (mismatches < 30)
            $display("%0t: expected no beat, actual kind=%0d status=%0d handle=%0d last=%0d",
                     $time, got.kind, got.status, got.handle, got.last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            if (mismatches < 30)
              $display({"%0t: mismatch expected kind=%0d status=%0d handle=%0d last=%0d,",
                        " actual kind=%0d status=%0d handle=%0d last=%0d"},
                       $time, want.kind, want.status, want.handle, want.last,
                       got.kind, got.status, got.handle, got.last);
            mismatches++;
          end
        end
      end
      if (stall_cnt != 0) begin
        stall_cnt--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_cnt = pick_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt == IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic [tsp_pkg::HANDLE_W-1:0] h,
                         input logic [tsp_pkg::PERIOD_W-1:0] p, input logic rel,
                         input logic ntf, input logic [tsp_pkg::TIME_W-1:0] t);
    pool_cmd_t c;
    c.op     = op;
    c.handle = h;
    c.period = p;
    c.reload = rel;
    c.notify = ntf;
    c.now    = t;
    pending_cmds.push_back(c);
  endtask

  task automatic add_random_cmd();
    int unsigned r;
    logic [2:0] op;
    logic [tsp_pkg::HANDLE_W-1:0] h;
    logic [tsp_pkg::PERIOD_W-1:0] p;
    r = $urandom_range(0, 29);
    if (r == 0)
      sim_ms = tsp_pkg::TIME_W'({$urandom, $urandom});
    else if (r == 1)
      sim_ms = tsp_pkg::TIME_MAX - tsp_pkg::TIME_W'($urandom_range(0, 40));
    else
      sim_ms = sim_ms + tsp_pkg::TIME_W'($urandom_range(0, 30));
    h = ($urandom_range(0, 9) == 0) ? tsp_pkg::HANDLE_W'($urandom_range(0, 15))
                                    : tsp_pkg::HANDLE_W'($urandom_range(1, SLOTS));
    case ($urandom_range(0, 19))
      0:       p = '0;
      1:       p = $urandom;
      2:       p = '1;
      default: p = $urandom_range(1, 60);
    endcase
    r = $urandom_range(0, 99);
    if (r < 18)      op = tsp_pkg::OP_CREATE;
    else if (r < 38) op = tsp_pkg::OP_START;
    else if (r < 48) op = tsp_pkg::OP_RESTART;
    else if (r < 78) op = tsp_pkg::OP_POLL;
    else if (r < 86) op = tsp_pkg::OP_STOP;
    else if (r < 95) op = tsp_pkg::OP_DELETE;
    else             op = 3'($urandom_range(6, 7));
    add_cmd(op, h, p, 1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0, sim_ms);
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() != 0 || s_tvalid || expected_beats.size() != 0)
      @(negedge clk);
    repeat (SLOTS + 4) @(negedge clk);
  endtask

  task automatic set_pool_enable(input bit v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pool_on = v;
    @(negedge clk);
  endtask

  initial begin
    pool_on = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      slot_on[k]  = 1'b0;
      slot_rel[k] = 1'b0;
      slot_ntf[k] = 1'b0;
      slot_per[k] = '0;
      slot_due[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // disabled pool, bad handles, unknown ops
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd5, 1'b1, 1'b1, '0);
    add_cmd(tsp_pkg::OP_POLL, 4'd0, 32'd0, 1'b0, 1'b0, tsp_pkg::TIME_MAX);
    add_cmd(tsp_pkg::OP_START, 4'd1, 32'd0, 1'b0, 1'b0, 48'd7);
    add_cmd(tsp_pkg::OP_STOP, 4'd0, 32'd0, 1'b0, 1'b0, '0);
    add_cmd(tsp_pkg::OP_STOP, 4'd3, 32'd0, 1'b0, 1'b0, '0);
    add_cmd(tsp_pkg::OP_DELETE, 4'd15, '1, 1'b1, 1'b1, tsp_pkg::TIME_MAX);
    add_cmd(3'd6, 4'd1, 32'd1, 1'b0, 1'b0, '0);
    add_cmd(3'd7, 4'd2, 32'd1, 1'b1, 1'b1, '0);
    drain();

    // fill the pool, saturating deadline, multi-expiry poll
    set_pool_enable(1'b1);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd0, 1'b1, 1'b1, '0);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, '1, 1'b1, 1'b1, '0);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd10, 1'b0, 1'b1, '0);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd3, 1'b1, 1'b1, '0);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd7, 1'b0, 1'b0, '0);
    for (int k = 0; k < 4; k++) add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd1, 1'b1, 1'b1, '0);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd2, 1'b0, 1'b1, '0);
    add_cmd(tsp_pkg::OP_START, 4'd1, 32'd0, 1'b0, 1'b0, tsp_pkg::TIME_MAX - 3);
    add_cmd(tsp_pkg::OP_START, 4'd2, 32'd0, 1'b0, 1'b0, '0);
    add_cmd(tsp_pkg::OP_RESTART, 4'd3, 32'd0, 1'b0, 1'b0, 48'd100);
    add_cmd(tsp_pkg::OP_RESTART, 4'd9, 32'd0, 1'b0, 1'b0, 48'd100);
    add_cmd(tsp_pkg::OP_POLL, 4'd0, 32'd0, 1'b0, 1'b0, 48'd5);
    add_cmd(tsp_pkg::OP_POLL, 4'd0, 32'd0, 1'b0, 1'b0, tsp_pkg::TIME_MAX);
    add_cmd(tsp_pkg::OP_DELETE, 4'd2, 32'd0, 1'b0, 1'b0, '0);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd4, 1'b0, 1'b1, '0);
    add_cmd(tsp_pkg::OP_STOP, 4'd1, 32'd0, 1'b0, 1'b0, '0);
    drain();

    // handle ops still work while disabled
    set_pool_enable(1'b0);
    add_cmd(tsp_pkg::OP_START, 4'd3, 32'd0, 1'b0, 1'b0, '0);
    add_cmd(tsp_pkg::OP_POLL, 4'd0, 32'd0, 1'b0, 1'b0, tsp_pkg::TIME_MAX);
    add_cmd(tsp_pkg::OP_CREATE, 4'd0, 32'd9, 1'b0, 1'b1, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_pool_enable((ph == 3) ? 1'b0 : ($urandom_range(0, 4) != 0));
      no_idle = (ph == 2);
      for (int n = 0; n < 15; n++) add_random_cmd();
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/tsp_pkg.sv
src/tsp_cell.sv
src/timer_slot_pool.sv
src/tsp_checker.sv
tb/timer_slot_pool_test.sv
